/* rtl/jawl_pkg.sv */
// package for the joint angle wrap-to-limits block
// holds angle types, the joint limit table and fixed-point constants; no dependencies

package jawl_pkg;

	localparam int ANGLE_W       = 24;
	localparam int IDX_W         = 3;
	localparam int NUM_JOINTS    = 7;
	localparam int LIMIT_ENTRIES = 7;
	// two pi in Q7.16
	localparam int TWO_PI_Q      = 411775;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [IDX_W-1:0]          joint_idx_t;

	function automatic angle_t lim_lo(input joint_idx_t j);
		angle_t r;
		unique case (j)
			3'd0:    r = -24'sd686291;
			3'd1:    r = 24'sd52616;
			3'd2:    r = -24'sd686291;
			3'd3:    r = 24'sd34315;
			3'd4:    r = -24'sd686291;
			3'd5:    r = 24'sd74348;
			3'd6:    r = -24'sd686291;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic angle_t lim_hi(input joint_idx_t j);
		angle_t r;
		unique case (j)
			3'd0:    r = 24'sd686291;
			3'd1:    r = 24'sd356872;
			3'd2:    r = 24'sd686291;
			3'd3:    r = 24'sd377460;
			3'd4:    r = 24'sd686291;
			3'd5:    r = 24'sd336283;
			3'd6:    r = 24'sd686291;
			default: r = '0;
		endcase
		return r;
	endfunction

	// joint has a limit entry and belongs to the vector
	function automatic logic joint_known(input joint_idx_t j);
		return (int'(j) < LIMIT_ENTRIES) && (int'(j) < NUM_JOINTS);
	endfunction

endpackage

/* rtl/jawl_joint_if.sv */
// input channel: one joint beat with index, solved and reference angle
// depends on jawl_pkg

interface jawl_joint_if;
	logic                 valid;
	logic                 ready;
	jawl_pkg::joint_idx_t joint_index;
	jawl_pkg::angle_t     solved_angle;
	jawl_pkg::angle_t     reference_angle;

	modport source (output valid, output joint_index, output solved_angle,
		output reference_angle, input ready);
	modport sink (input valid, input joint_index, input solved_angle,
		input reference_angle, output ready);
endinterface

/* rtl/jawl_result_if.sv */
// output channel: adjusted angle with found, vector and last-joint flags
// depends on jawl_pkg

interface jawl_result_if;
	logic             valid;
	logic             ready;
	jawl_pkg::angle_t adjusted_angle;
	logic             found;
	logic             vector_ok;
	logic             last_joint;

	modport source (output valid, output adjusted_angle, output found,
		output vector_ok, output last_joint, input ready);
	modport sink (input valid, input adjusted_angle, input found,
		input vector_ok, input last_joint, output ready);
endinterface

/* rtl/joint_angle_wrap_to_limits_core.sv */
// joint angle wrap-to-limits core: three register stages, one beat per cycle unless stalled
// depends on jawl_pkg, jawl_joint_if, jawl_result_if
//
// Usage:
//   joint carries one joint per beat: index, solved angle and reference angle,
//   signed Q7.16 radians. The core tries angle + k*2pi for k in
//   -WRAP_TURNS..WRAP_TURNS, keeps those inside the joint's limit pair and
//   returns the one nearest the reference (lowest k on a tie), or the solved
//   angle with found low when none fits.
//   result carries the adjusted angle, found, vector_ok (every joint since the
//   last joint 0 was found, this one included) and last_joint.
//   Path: a beat taken from joint passes the input register, the candidate
//   register and the result register before it shows on result.
//   Throughput: one beat per cycle unless result stalls; every candidate lane
//   has its own adder and limit compare, and the nearest-candidate pick is one pass over the lanes.
//   Stall: when result is not taken the stages fill and joint.ready drops
//   once all three hold a beat; nothing is dropped or repeated.
//   Reset: all stages empty, vector flag set.

module joint_angle_wrap_to_limits_core #(
	parameter int WRAP_TURNS = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	jawl_joint_if.sink         joint,
	jawl_result_if.source      result
);

	localparam int NC     = 2 * WRAP_TURNS + 1;
	localparam int CAND_W = $clog2(2 ** (jawl_pkg::ANGLE_W - 1)
		+ WRAP_TURNS * jawl_pkg::TWO_PI_Q) + 1;
	localparam int DIFF_W = CAND_W + 1;
	localparam int ERR_W  = CAND_W;

	// stage 1: input register
	logic                 v_s1;
	jawl_pkg::joint_idx_t idx_s1;
	jawl_pkg::angle_t     angle_s1;
	jawl_pkg::angle_t     ref_s1;

	// stage 2: candidates
	logic                       v_s2;
	jawl_pkg::joint_idx_t       idx_s2;
	jawl_pkg::angle_t           angle_s2;
	logic signed [CAND_W-1:0]   cand_s2 [NC];
	logic [ERR_W-1:0]           err_s2 [NC];
	logic [NC-1:0]              hit_s2;

	// result register
	logic             out_valid_q;
	jawl_pkg::angle_t out_angle_q;
	logic             out_found_q;
	logic             out_vec_q;
	logic             out_last_q;
	logic             all_found_q;

	logic adv_o, adv_s2, adv_s1;

	assign adv_o  = !out_valid_q || result.ready;
	assign adv_s2 = !v_s2 || adv_o;
	assign adv_s1 = !v_s1 || adv_s2;
	assign joint.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= joint.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && joint.valid) begin
			idx_s1   <= joint.joint_index;
			angle_s1 <= joint.solved_angle;
			ref_s1   <= joint.reference_angle;
		end
	end

	// per-lane candidate, limit check and distance
	logic signed [CAND_W-1:0] lo_c, hi_c;
	logic                     known_c;
	logic signed [CAND_W-1:0] cand_c [NC];
	logic [ERR_W-1:0]         err_c [NC];
	logic [NC-1:0]            hit_c;

	assign lo_c    = CAND_W'(jawl_pkg::lim_lo(idx_s1));
	assign hi_c    = CAND_W'(jawl_pkg::lim_hi(idx_s1));
	assign known_c = jawl_pkg::joint_known(idx_s1);

	for (genvar l = 0; l < NC; l++) begin : g_lane
		localparam logic signed [CAND_W-1:0] OFF =
			CAND_W'((l - WRAP_TURNS) * jawl_pkg::TWO_PI_Q);
		logic signed [DIFF_W-1:0] diff;

		assign cand_c[l] = CAND_W'(angle_s1) + OFF;
		assign hit_c[l]  = known_c && (cand_c[l] >= lo_c) && (cand_c[l] <= hi_c);
		assign diff      = DIFF_W'(cand_c[l]) - DIFF_W'(ref_s1);
		assign err_c[l]  = diff[DIFF_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			idx_s2   <= idx_s1;
			angle_s2 <= angle_s1;
			cand_s2  <= cand_c;
			err_s2   <= err_c;
			hit_s2   <= hit_c;
		end
	end

	// nearest candidate, strict compare keeps the lowest k on a tie
	logic                     sel_found;
	logic [ERR_W-1:0]         sel_err;
	logic signed [CAND_W-1:0] sel_cand;
	jawl_pkg::angle_t         adj_c;
	logic                     first_c, last_c, vec_c;

	always_comb begin
		sel_found = 1'b0;
		sel_err   = '0;
		sel_cand  = '0;
		for (int l = 0; l < NC; l++) begin
			if (hit_s2[l] && (!sel_found || err_s2[l] < sel_err)) begin
				sel_found = 1'b1;
				sel_err   = err_s2[l];
				sel_cand  = cand_s2[l];
			end
		end
	end

	assign adj_c   = sel_found ? sel_cand[jawl_pkg::ANGLE_W-1:0] : angle_s2;
	assign first_c = (idx_s2 == '0);
	assign last_c  = (int'(idx_s2) == jawl_pkg::NUM_JOINTS - 1);
	assign vec_c   = (first_c || all_found_q) && sel_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			all_found_q <= 1'b1;
		end else if (adv_o) begin
			out_valid_q <= v_s2;
			if (v_s2) begin
				all_found_q <= vec_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o && v_s2) begin
			out_angle_q <= adj_c;
			out_found_q <= sel_found;
			out_vec_q   <= vec_c;
			out_last_q  <= last_c;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.adjusted_angle = out_angle_q;
	assign result.found          = out_found_q;
	assign result.vector_ok      = out_vec_q;
	assign result.last_joint     = out_last_q;

	// a joint that was not found can never leave the vector flag set
	a_vec_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.found) |-> !result.vector_ok)
		else $error("vector_ok set on a joint that was not found");

	// the vector flag only recovers on a joint 0 beat
	a_vec_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(all_found_q) |-> $past(adv_o && v_s2 && first_c))
		else $error("vector flag set again without a joint 0");

	// a stalled input stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s2) |=> (v_s1 && $stable(angle_s1) && $stable(idx_s1)))
		else $error("input stage lost its beat under stall");

	// a stalled candidate stage keeps its beat
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv_o) |=> (v_s2 && $stable(hit_s2) && $stable(angle_s2)))
		else $error("candidate stage lost its beat under stall");

endmodule
